[rtl/rlen_pkg.sv]
// Shared types and constants for the ring leader election node.
// Holds field widths, code names and the queue entry layout.
// No dependencies; every other rtl file imports this package.
package rlen_pkg;

   localparam int ID_W        = 8;
   localparam int HOP_W       = 9;
   localparam int PHASE_W     = 4;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 1;

   localparam logic [PHASE_W-1:0] PHASE_MAX = 4'd8;

   // request selector (tuser)
   localparam logic FUNC_MSG   = 1'b0;
   localparam logic FUNC_START = 1'b1;

   // message direction
   localparam logic DIR_OUT = 1'b0;
   localparam logic DIR_IN  = 1'b1;

   // send side
   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   // result kind
   localparam logic KIND_MSG    = 1'b0;
   localparam logic KIND_LEADER = 1'b1;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE = 1'b1;

   typedef logic [ID_W-1:0]    id_type;
   typedef logic [HOP_W-1:0]   hop_type;
   typedef logic [PHASE_W-1:0] phase_type;

   // one result, without the last marker
   typedef struct packed {
      logic    kind;
      logic    to_side;
      logic    out_direction;
      hop_type out_hops;
      id_type  out_candidate;
   } rlen_result_type;

   // one queue entry: one or two results of a single request
   typedef struct packed {
      logic            two;
      rlen_result_type res0;
      rlen_result_type res1;
   } rlen_entry_type;

   // election state, for checking at the top level
   typedef struct packed {
      phase_type phase;
      logic      left_ready;
      logic      right_ready;
   } rlen_status_type;

endpackage

[rtl/rlen_front.sv]
// Front end: takes requests, holds config and election state, classifies each request.
// Pushes one entry with one or two results into the queue. Depends on rlen_pkg.
module rlen_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rlen_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rlen_pkg::ID_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_func,
   input  logic [rlen_pkg::ID_W-1:0]        req_sender,
   input  logic                             req_direction,
   input  logic [rlen_pkg::HOP_W-1:0]       req_hops,
   input  logic [rlen_pkg::ID_W-1:0]        req_candidate,
   input  logic                             q_full,
   output logic                             req_ready,
   output logic                             push,
   output rlen_pkg::rlen_entry_type         push_entry,
   output rlen_pkg::rlen_status_type        status
);
   import rlen_pkg::*;

   id_type    own_id_ff, own_id_in;
   id_type    ring_size_ff, ring_size_in;
   phase_type phase_ff, phase_in;
   logic      left_ready_ff, left_ready_in;
   logic      right_ready_ff, right_ready_in;

   id_type    left_id, right_id;
   logic      from_left, from_right, fwd_side;
   logic      lr_set, rr_set;
   phase_type phase_up;
   logic [1:0] num_res;
   logic      accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // neighbour ids, wrapping around the ring
   assign left_id  = (own_id_ff > 8'd1) ? own_id_ff - 8'd1 : ring_size_ff;
   assign right_id = ({1'b0, own_id_ff} + 9'd1 > {1'b0, ring_size_ff}) ? 8'd1
                     : own_id_ff + 8'd1;
   assign from_left  = (req_sender == left_id);
   assign from_right = (req_sender == right_id);
   assign fwd_side   = from_left ? SIDE_RIGHT : SIDE_LEFT;
   assign lr_set     = left_ready_ff  || from_left;
   assign rr_set     = right_ready_ff || from_right;
   assign phase_up   = (phase_ff < PHASE_MAX) ? phase_ff + 4'd1 : phase_ff;

   // classify the request
   always_comb begin
      num_res        = 2'd0;
      push_entry     = '0;
      phase_in       = phase_ff;
      left_ready_in  = left_ready_ff;
      right_ready_in = right_ready_ff;
      priority if (req_func == FUNC_START) begin
         phase_in       = '0;
         left_ready_in  = 1'b0;
         right_ready_in = 1'b0;
         num_res        = 2'd2;
         push_entry.res0 = '{KIND_MSG, SIDE_RIGHT, DIR_OUT, 9'd1, own_id_ff};
         push_entry.res1 = '{KIND_MSG, SIDE_LEFT,  DIR_OUT, 9'd1, own_id_ff};
      end else if (req_direction == DIR_OUT) begin
         if (from_left || from_right) begin
            priority if (req_candidate == own_id_ff) begin
               num_res = 2'd1;
               push_entry.res0 = '{KIND_LEADER, 1'b0, 1'b0, 9'd0, 8'd0};
            end else if (req_candidate > own_id_ff && req_hops > 9'd1) begin
               num_res = 2'd1;
               push_entry.res0 = '{KIND_MSG, fwd_side, DIR_OUT, req_hops - 9'd1,
                                   req_candidate};
            end else if (req_candidate > own_id_ff && req_hops == 9'd1) begin
               // last hop: turn the probe back
               num_res = 2'd1;
               push_entry.res0 = '{KIND_MSG, ~fwd_side, DIR_IN, 9'd1, req_candidate};
            end else begin
               num_res = 2'd0;
            end
         end
      end else if (req_hops == 9'd1) begin
         if (req_candidate != own_id_ff) begin
            // relay reply; right goes first when both neighbours match
            priority if (from_left && from_right) begin
               num_res = 2'd2;
               push_entry.res0 = '{KIND_MSG, SIDE_RIGHT, DIR_IN, 9'd1, req_candidate};
               push_entry.res1 = '{KIND_MSG, SIDE_LEFT,  DIR_IN, 9'd1, req_candidate};
            end else if (from_left) begin
               num_res = 2'd1;
               push_entry.res0 = '{KIND_MSG, SIDE_RIGHT, DIR_IN, 9'd1, req_candidate};
            end else if (from_right) begin
               num_res = 2'd1;
               push_entry.res0 = '{KIND_MSG, SIDE_LEFT,  DIR_IN, 9'd1, req_candidate};
            end else begin
               num_res = 2'd0;
            end
         end else if (lr_set && rr_set) begin
            // both sides answered: next phase, fresh probes
            phase_in       = phase_up;
            left_ready_in  = 1'b0;
            right_ready_in = 1'b0;
            num_res        = 2'd2;
            push_entry.res0 = '{KIND_MSG, SIDE_RIGHT, DIR_OUT, 9'd1 << phase_up, own_id_ff};
            push_entry.res1 = '{KIND_MSG, SIDE_LEFT,  DIR_OUT, 9'd1 << phase_up, own_id_ff};
         end else begin
            left_ready_in  = lr_set;
            right_ready_in = rr_set;
         end
      end
      push_entry.two = num_res[1];
   end

   assign push = accept && (num_res != 2'd0);

   // config writes
   always_comb begin
      own_id_in    = own_id_ff;
      ring_size_in = ring_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ID:    own_id_in    = csr_wdata;
            CSR_RING_SIZE: ring_size_in = csr_wdata;
            default:       own_id_in    = own_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff      <= 8'd1;
         ring_size_ff   <= 8'd1;
         phase_ff       <= '0;
         left_ready_ff  <= 1'b0;
         right_ready_ff <= 1'b0;
      end else begin
         own_id_ff    <= own_id_in;
         ring_size_ff <= ring_size_in;
         if (accept) begin
            phase_ff       <= phase_in;
            left_ready_ff  <= left_ready_in;
            right_ready_ff <= right_ready_in;
         end
      end
   end

   assign status = '{phase_ff, left_ready_ff, right_ready_ff};

endmodule

[rtl/rlen_queue.sv]
// Two-entry queue between the front end and the back end.
// Each entry carries all results of one request. Depends on rlen_pkg.
module rlen_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rlen_pkg::rlen_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output rlen_pkg::rlen_entry_type head_entry
);
   import rlen_pkg::*;

   rlen_entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/rlen_back.sv]
// Back end: takes queue entries apart into single results, one per cycle if rsp_ready.
// Drives the response output register and marks the last result. Depends on rlen_pkg.
module rlen_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  rlen_pkg::rlen_entry_type          head_entry,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rlen_pkg::rlen_result_type         rsp_result,
   output logic                              rsp_last
);
   import rlen_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rlen_result_type out_res_ff, out_res_in;
   logic            out_last_ff, out_last_in;
   logic            pend_valid_ff, pend_valid_in;
   rlen_result_type pend_res_ff, pend_res_in;
   logic            out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = head_valid && !pend_valid_ff && out_free;

   // load the output register: held second result first, then the queue head
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_res_in    = out_res_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_res_in   = pend_res_ff;
      if (out_free) begin
         priority if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = pend_res_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (head_valid) begin
            out_valid_in  = 1'b1;
            out_res_in    = head_entry.res0;
            out_last_in   = !head_entry.two;
            pend_valid_in = head_entry.two;
            pend_res_in   = head_entry.res1;
         end else begin
            out_valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
      pend_res_ff <= pend_res_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_res_ff;
   assign rsp_last   = out_last_ff;

endmodule

[rtl/ring_leader_election_node_top.sv]
// Top level of one ring leader election node.
// Ties together rlen_front, rlen_queue and rlen_back; depends on rlen_pkg.
//
// One node of a bidirectional ring doing phase-doubling leader election. A request is
// either a start command (tuser 1) or a received message (tuser 0); each request yields
// zero, one or two results, the final one flagged by rsp_tlast. A result with tuser 1
// declares this node leader. The output port gives one result per cycle while
// rsp_tready is high; with a ready consumer the node takes a request every cycle until
// its two-entry queue fills. Results pass the queue register, then the output register.
// The user must write own_id and ring_size through the csr port only while no request
// is in flight; the block does not enforce this. Both reset to 1.
module ring_leader_election_node_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // config write port
   input  logic                                 csr_we,
   input  logic [rlen_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rlen_pkg::ID_W-1:0]            csr_wdata,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] sender_id, [8] direction, [17:9] hops_left, [25:18] candidate_id
   input  logic [rlen_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] func
   input  logic                                 req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] to_side, [1] out_direction, [10:2] out_hops, [18:11] out_candidate
   output logic [rlen_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] kind
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import rlen_pkg::*;

   logic            q_full, q_push, q_pop, q_head_valid;
   rlen_entry_type  q_push_entry, q_head_entry;
   rlen_status_type elect_status;
   rlen_result_type rsp_result;

   rlen_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_tvalid),
      .req_func      (req_tuser),
      .req_sender    (req_tdata[7:0]),
      .req_direction (req_tdata[8]),
      .req_hops      (req_tdata[17:9]),
      .req_candidate (req_tdata[25:18]),
      .q_full        (q_full),
      .req_ready     (req_tready),
      .push          (q_push),
      .push_entry    (q_push_entry),
      .status        (elect_status)
   );

   rlen_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   rlen_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_tlast)
   );

   // pack the response
   assign rsp_tuser = rsp_result.kind;
   assign rsp_tdata = {5'd0, rsp_result.out_candidate, rsp_result.out_hops,
                       rsp_result.out_direction, rsp_result.to_side};

   // a reply for the own id never leaves both ready flags standing
   a_ready_not_both: assert property (@(posedge clock) disable iff (reset)
      !(elect_status.left_ready && elect_status.right_ready))
      else $error("both ready flags set at once");

   // phase saturates at its bound
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      elect_status.phase <= PHASE_MAX)
      else $error("phase beyond bound");

   // the second result of a request follows right after the first is taken
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result not presented");

   // a start command always pushes two results
   a_start_pushes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_START |-> q_push && q_push_entry.two)
      else $error("start command without probes");

endmodule

[tb/tb_ring_leader_election_node_top.sv]
// Self-checking testbench for ring_leader_election_node_top.
// Predicts the node's sends and leader declarations and checks them in order.
// Depends on rlen_pkg and the node RTL only.
module tb_ring_leader_election_node_top;
   import rlen_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   // one request as seen by the node
   typedef struct packed {
      logic    func;
      id_type  sender;
      logic    dir;
      hop_type hops;
      id_type  cand;
   } node_req_type;

   // one result: a send or a leader declaration
   typedef struct packed {
      logic    kind;
      logic    side;
      logic    dir;
      hop_type hops;
      id_type  cand;
      logic    last;
   } node_rsp_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [ID_W-1:0]        csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   ring_leader_election_node_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // request backlog and expected sends
   node_req_type req_backlog[$];
   node_rsp_type node_outbox[$];

   // node state as predicted
   int   node_id = 1;
   int   ring_len = 1;
   int   cur_phase = 0;
   logic left_rdy = 1'b0;
   logic right_rdy = 1'b0;

   // pacing knobs and counters
   int   gap_pct = 0;
   int   stall_pct = 0;
   logic calm = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   quiet_cycles = 0;
   int   fail_count = 0;
   int   req_taken = 0;
   int   rsp_checked = 0;
   int   leader_seen = 0;
   int   top_phase = 0;
   int   settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic node_rsp_type make_send(logic kind, logic side, logic dir,
                                              hop_type hops, id_type cand);
      node_rsp_type m;
      m = {kind, side, dir, hops, cand, 1'b0};
      return m;
   endfunction

   // next state and sends of the node for one accepted request
   task automatic predict_node_step(input node_req_type rq);
      node_rsp_type outs[2];
      int        n;
      int        left_id;
      int        right_id;
      logic      from_l;
      logic      from_r;
      logic      fwd;
      hop_type   probe;
      n = 0;
      left_id = (node_id > 1) ? node_id - 1 : ring_len;
      right_id = (node_id + 1 > ring_len) ? 1 : node_id + 1;
      from_l = (rq.sender == left_id);
      from_r = (rq.sender == right_id);
      if (rq.func == FUNC_START) begin
         cur_phase = 0;
         left_rdy = 1'b0;
         right_rdy = 1'b0;
         outs[0] = make_send(KIND_MSG, SIDE_RIGHT, DIR_OUT, 1, id_type'(node_id));
         outs[1] = make_send(KIND_MSG, SIDE_LEFT, DIR_OUT, 1, id_type'(node_id));
         n = 2;
      end else if (rq.dir == DIR_OUT) begin
         // a same-id pair of neighbours counts as the left one
         fwd = from_l ? SIDE_RIGHT : SIDE_LEFT;
         if (from_l || from_r) begin
            if (rq.cand == node_id) begin
               outs[0] = make_send(KIND_LEADER, SIDE_LEFT, DIR_OUT, 0, 0);
               n = 1;
            end else if (rq.cand > node_id && rq.hops > 1) begin
               outs[0] = make_send(KIND_MSG, fwd, DIR_OUT, hop_type'(rq.hops - 1), rq.cand);
               n = 1;
            end else if (rq.cand > node_id && rq.hops == 1) begin
               outs[0] = make_send(KIND_MSG, ~fwd, DIR_IN, 1, rq.cand);
               n = 1;
            end
         end
      end else if (rq.hops == 1) begin
         if (rq.cand != node_id) begin
            // relay; both ways when the two neighbours share an id
            if (from_l) begin
               outs[n] = make_send(KIND_MSG, SIDE_RIGHT, DIR_IN, 1, rq.cand);
               n = n + 1;
            end
            if (from_r) begin
               outs[n] = make_send(KIND_MSG, SIDE_LEFT, DIR_IN, 1, rq.cand);
               n = n + 1;
            end
         end else begin
            if (from_r) right_rdy = 1'b1;
            if (from_l) left_rdy = 1'b1;
         end
         // both replies in: next phase, probes twice as far
         if (left_rdy && right_rdy) begin
            if (cur_phase < PHASE_MAX) cur_phase = cur_phase + 1;
            if (cur_phase > top_phase) top_phase = cur_phase;
            left_rdy = 1'b0;
            right_rdy = 1'b0;
            probe = hop_type'(1 << cur_phase);
            outs[0] = make_send(KIND_MSG, SIDE_RIGHT, DIR_OUT, probe, id_type'(node_id));
            outs[1] = make_send(KIND_MSG, SIDE_LEFT, DIR_OUT, probe, id_type'(node_id));
            n = 2;
         end
      end
      for (int i = 0; i < n; i++) begin
         outs[i].last = (i == n - 1);
         node_outbox.push_back(outs[i]);
      end
   endtask

   task automatic queue_req(input logic func, input id_type sender, input logic dir,
                            input hop_type hops, input id_type cand);
      node_req_type rq;
      rq = {func, sender, dir, hops, cand};
      req_backlog.push_back(rq);
   endtask

   function automatic hop_type pick_hops();
      case ($urandom_range(0, 5))
         0: return 0;
         1, 2: return 1;
         3: return 256;
         default: return hop_type'($urandom_range(2, 255));
      endcase
   endfunction

   // random traffic, mostly well-formed for the current node setting
   task automatic gen_traffic(input int count);
      int     left_id;
      int     right_id;
      int     sel;
      id_type nb;
      id_type other;
      id_type cand;
      left_id = (node_id > 1) ? node_id - 1 : ring_len;
      right_id = (node_id + 1 > ring_len) ? 1 : node_id + 1;
      for (int k = 0; k < count; k++) begin
         nb = id_type'($urandom_range(0, 1) ? left_id : right_id);
         other = id_type'((nb == left_id) ? right_id : left_id);
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            queue_req(FUNC_START, id_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      hop_type'($urandom_range(0, 256)), id_type'($urandom_range(0, 255)));
         end else if (sel < 33) begin
            // own replies from both sides, either order
            queue_req(FUNC_MSG, nb, DIR_IN, 1, id_type'(node_id));
            queue_req(FUNC_MSG, other, DIR_IN, 1, id_type'(node_id));
            k = k + 1;
         end else if (sel < 45) begin
            queue_req(FUNC_MSG, nb, DIR_OUT, pick_hops(), id_type'(node_id));
         end else if (sel < 65) begin
            cand = (node_id < 255 && $urandom_range(0, 3) != 0) ?
                   id_type'($urandom_range(node_id + 1, 255)) :
                   id_type'($urandom_range(0, 255));
            queue_req(FUNC_MSG, nb, DIR_OUT, pick_hops(), cand);
         end else if (sel < 78) begin
            queue_req(FUNC_MSG, nb, DIR_IN, 1, id_type'($urandom_range(0, 255)));
         end else if (sel < 88) begin
            queue_req(FUNC_MSG, nb, DIR_IN, pick_hops(), id_type'($urandom_range(0, 255)));
         end else begin
            queue_req(FUNC_MSG, id_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      hop_type'($urandom_range(0, 256)), id_type'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= id_type'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OWN_ID) node_id = val;
      else ring_len = val;
   endtask

   // all requests taken, all sends seen, then a settling wait for silent ones
   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || node_outbox.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      node_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.func;
            req_tdata <= {6'b0, nxt.cand, nxt.hops, nxt.dir, nxt.sender};
            if (!calm && $urandom_range(0, 99) < gap_pct)
               req_gap <= $urandom_range(1, 11);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         rsp_stall <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check results, predict on each accepted request, watchdog
   always @(posedge clock) begin
      node_rsp_type got;
      node_rsp_type want;
      node_req_type taken;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[0], rsp_tdata[1], rsp_tdata[10:2],
                   rsp_tdata[18:11], rsp_tlast};
            rsp_checked++;
            if (got.kind == KIND_LEADER) leader_seen++;
            if (node_outbox.size() == 0) begin
               $display("%0t: unexpected result kind=%0d side=%0d dir=%0d hops=%0d cand=%0d last=%0d",
                        $time, got.kind, got.side, got.dir, got.hops, got.cand, got.last);
               fail_count++;
            end else begin
               want = node_outbox.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected kind=%0d side=%0d dir=%0d hops=%0d cand=%0d last=%0d",
                           $time, want.kind, want.side, want.dir, want.hops, want.cand, want.last);
                  $display("%0t:          actual   kind=%0d side=%0d dir=%0d hops=%0d cand=%0d last=%0d",
                           $time, got.kind, got.side, got.dir, got.hops, got.cand, got.last);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            taken = {req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[17:9], req_tdata[25:18]};
            req_taken++;
            predict_node_step(taken);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus: directed checks, then random traffic over several node settings
   initial begin
      int cfg_own[7];
      int cfg_ring[7];
      int own_v;
      int ring_v;
      cfg_own = '{1, 1, 2, 255, 1, 255, 128};
      cfg_ring = '{1, 2, 2, 255, 255, 1, 200};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // node 5 of 8: left neighbour 4, right neighbour 6
      write_csr(CSR_OWN_ID, 5);
      write_csr(CSR_RING_SIZE, 8);
      settings_used++;
      @(negedge clock);
      gap_pct = 30;
      stall_pct = 20;
      queue_req(FUNC_START, 255, DIR_IN, 256, 255);
      queue_req(FUNC_MSG, 4, DIR_OUT, 1, 5);     // own id back out: leader
      queue_req(FUNC_MSG, 6, DIR_OUT, 3, 200);   // forward, one hop less
      queue_req(FUNC_MSG, 4, DIR_OUT, 1, 9);     // last hop: turned back
      queue_req(FUNC_MSG, 6, DIR_OUT, 256, 255); // longest probe, top id
      queue_req(FUNC_MSG, 4, DIR_OUT, 0, 7);     // no hops left: dropped
      queue_req(FUNC_MSG, 4, DIR_OUT, 4, 3);     // smaller candidate
      queue_req(FUNC_MSG, 4, DIR_OUT, 1, 0);
      queue_req(FUNC_MSG, 0, DIR_OUT, 2, 200);   // unknown senders
      queue_req(FUNC_MSG, 255, DIR_OUT, 2, 200);
      queue_req(FUNC_MSG, 4, DIR_IN, 1, 9);      // relays
      queue_req(FUNC_MSG, 6, DIR_IN, 1, 2);
      queue_req(FUNC_MSG, 4, DIR_IN, 2, 9);      // reply hop count not one
      queue_req(FUNC_MSG, 6, DIR_IN, 0, 9);
      queue_req(FUNC_MSG, 6, DIR_IN, 256, 5);
      queue_req(FUNC_MSG, 6, DIR_IN, 1, 5);      // own replies: phase 1
      queue_req(FUNC_MSG, 6, DIR_IN, 1, 5);
      queue_req(FUNC_MSG, 4, DIR_IN, 1, 5);
      queue_req(FUNC_MSG, 4, DIR_IN, 1, 5);      // phase 2
      queue_req(FUNC_MSG, 6, DIR_IN, 1, 5);
      queue_req(FUNC_MSG, 4, DIR_IN, 1, 5);      // start drops a pending ready
      queue_req(FUNC_START, 0, DIR_OUT, 0, 0);
      queue_req(FUNC_MSG, 6, DIR_IN, 1, 5);
      queue_req(FUNC_MSG, 4, DIR_IN, 1, 5);

      // random traffic; includes shared and self neighbours and both extremes
      for (int p = 0; p < 9; p++) begin
         wait_idle();
         if (p < 7) begin
            own_v = cfg_own[p];
            ring_v = cfg_ring[p];
         end else begin
            own_v = $urandom_range(1, 255);
            ring_v = $urandom_range(1, 255);
         end
         write_csr(CSR_OWN_ID, own_v);
         write_csr(CSR_RING_SIZE, ring_v);
         settings_used++;
         @(negedge clock);
         gap_pct = (p % 3) * 25;
         stall_pct = ((p + 1) % 3) * 15;
         calm = (p == 8);
         gen_traffic((p < 8) ? 100 : 60);
      end

      wait_idle();
      $display("Covered %0d requests over %0d node settings: %0d results checked,",
               req_taken, settings_used, rsp_checked);
      $display("%0d leader declarations, highest phase reached %0d.", leader_seen, top_phase);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
